// File: hw/rtl/bounded_priority_queue_assert.svh
// Assertion macros shared by the queue modules.
// Each macro takes a label, an antecedent and a consequent, and samples on
// posedge clk with the check off while rst is high.
`ifndef BOUNDED_PRIORITY_QUEUE_ASSERT_SVH
`define BOUNDED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define BPQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpq assertion failed");

// Next-cycle implication
`define BPQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpq assertion failed");

`else

`define BPQ_ASSERT_IMP(lbl, ante, cons)
`define BPQ_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: hw/rtl/bpq_pkg.sv
package bpq_pkg;

  // Command codes; code 3 is unused and ignored
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_PEEK   = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_t;

  // Response status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [31:0] item_value;
    logic [15:0]        item_priority;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [15:0]        out_priority;
    status_t            status;
  } rsp_t;

  // Operation broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic del;
  } cell_op_t;

endpackage

// File: hw/rtl/bpq_cell.sv
`include "bounded_priority_queue_assert.svh"

module bpq_cell #(
  parameter int PRIO_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bpq_pkg::cell_op_t    op,
  input  logic signed [31:0]   new_value,
  input  logic [PRIO_BITS-1:0] new_prio,
  input  logic                 up_valid,
  input  logic signed [31:0]   up_value,
  input  logic [PRIO_BITS-1:0] up_prio,
  input  logic                 up_open,
  input  logic                 dn_valid,
  input  logic signed [31:0]   dn_value,
  input  logic [PRIO_BITS-1:0] dn_prio,
  output logic                 valid,
  output logic signed [31:0]   value,
  output logic [PRIO_BITS-1:0] prio,
  output logic                 open
);

  logic                 valid_next;
  logic signed [31:0]   value_next;
  logic [PRIO_BITS-1:0] prio_next;

  // Open means a new entry belongs here or above; equal priorities stay ahead
  assign open = !valid || (prio < new_prio);

  // Pick the next content: new entry, shift down, shift up, or hold
  always_comb begin
    valid_next = valid;
    value_next = value;
    prio_next  = prio;
    if (op.ins && open) begin
      if (up_open) begin
        valid_next = up_valid;
        value_next = up_value;
        prio_next  = up_prio;
      end else begin
        valid_next = 1'b1;
        value_next = new_value;
        prio_next  = new_prio;
      end
    end else if (op.del) begin
      valid_next = dn_valid;
      value_next = dn_value;
      prio_next  = dn_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    prio  <= prio_next;
  end

  // Chain stays sorted: no entry below outranks this one
  `BPQ_ASSERT_IMP(a_cell_sorted, valid && dn_valid, prio >= dn_prio)

endmodule

// File: hw/rtl/bounded_priority_queue.sv
// A response is registered at the transfer of its request.
// Throughput: one command per cycle while the response side keeps up; each
// cell does one compare and one neighbor shift per cycle, so DEPTH does not
// change the rate.
// Reset clears the cell valid bits and the response valid flag; stored values,
// priorities and response data are left as they were and are never read before written.
`include "bounded_priority_queue_assert.svh"

module bounded_priority_queue #(
  parameter int DEPTH     = 8,
  parameter int PRIO_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  bpq_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output bpq_pkg::rsp_t  rsp
);

  logic                 accept;
  logic                 full;
  logic                 empty;
  logic [PRIO_BITS-1:0] new_prio;
  bpq_pkg::cell_op_t    op;
  bpq_pkg::rsp_t        rsp_next;

  logic [DEPTH-1:0]           cell_valid;
  logic [DEPTH-1:0]           cell_open;
  logic signed [31:0]         cell_value [DEPTH];
  logic [PRIO_BITS-1:0]       cell_prio  [DEPTH];

  // Accept when the response slot is free or being emptied
  assign req_ready = !rst && (!rsp_valid || rsp_ready);
  assign accept    = req_valid && req_ready;

  // Sorted chain: head holds the best entry, valid bits fill from the head
  assign full     = cell_valid[DEPTH-1];
  assign empty    = !cell_valid[0];
  assign new_prio = PRIO_BITS'(req.item_priority);

  assign op.ins = accept && (req.cmd == bpq_pkg::CMD_INSERT) && !full;
  assign op.del = accept && (req.cmd == bpq_pkg::CMD_DELETE) && !empty;

  // Build the chain, each cell wired to its upper and lower neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 up_valid;
    logic signed [31:0]   up_value;
    logic [PRIO_BITS-1:0] up_prio;
    logic                 up_open;
    logic                 dn_valid;
    logic signed [31:0]   dn_value;
    logic [PRIO_BITS-1:0] dn_prio;

    if (i == 0) begin : g_head
      assign up_valid = 1'b0;
      assign up_value = '0;
      assign up_prio  = '0;
      assign up_open  = 1'b0;
    end else begin : g_mid_up
      assign up_valid = cell_valid[i-1];
      assign up_value = cell_value[i-1];
      assign up_prio  = cell_prio[i-1];
      assign up_open  = cell_open[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign dn_valid = 1'b0;
      assign dn_value = '0;
      assign dn_prio  = '0;
    end else begin : g_mid_dn
      assign dn_valid = cell_valid[i+1];
      assign dn_value = cell_value[i+1];
      assign dn_prio  = cell_prio[i+1];
    end

    bpq_cell #(
      .PRIO_BITS(PRIO_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .op       (op),
      .new_value(req.item_value),
      .new_prio (new_prio),
      .up_valid (up_valid),
      .up_value (up_value),
      .up_prio  (up_prio),
      .up_open  (up_open),
      .dn_valid (dn_valid),
      .dn_value (dn_value),
      .dn_prio  (dn_prio),
      .valid    (cell_valid[i]),
      .value    (cell_value[i]),
      .prio     (cell_prio[i]),
      .open     (cell_open[i])
    );
  end

  // Form the response from the command and the head cell
  always_comb begin
    rsp_next = '{out_value: '0, out_priority: '0, status: bpq_pkg::ST_OK};
    unique case (req.cmd)
      bpq_pkg::CMD_INSERT: begin
        if (full) begin
          rsp_next.status = bpq_pkg::ST_FULL;
        end
      end
      bpq_pkg::CMD_PEEK, bpq_pkg::CMD_DELETE: begin
        if (empty) begin
          rsp_next.status = bpq_pkg::ST_EMPTY;
        end else begin
          rsp_next.out_value    = cell_value[0];
          rsp_next.out_priority = 16'(cell_prio[0]);
        end
      end
      default: begin
        rsp_next.status = bpq_pkg::ST_OK;
      end
    endcase
  end

  // Hold the response until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // Valid bits always form a run from the head
  `BPQ_ASSERT_IMP(a_valid_run, 1'b1, (cell_valid & DEPTH'(cell_valid + 1'b1)) == '0)
  // A stored insert grows the queue by one entry
  `BPQ_ASSERT_NXT(a_ins_count, op.ins,
                  $countones(cell_valid) == $past($countones(cell_valid)) + 1)
  // A delete reports OK with the priority of the head entry it removed
  `BPQ_ASSERT_NXT(a_del_head, op.del,
                  rsp.status == bpq_pkg::ST_OK &&
                  rsp.out_priority == $past(16'(cell_prio[0])))
  // A full report stands only while the queue is still full
  `BPQ_ASSERT_IMP(a_full_rsp, rsp_valid && rsp.status == bpq_pkg::ST_FULL, full)

endmodule

// File: sim/bounded_priority_queue_check.sv
`timescale 1ns / 1ps

module bounded_priority_queue_check
  import bpq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  req_t        req,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  rsp_t        rsp,
  output int unsigned outstanding,
  output int          errors
);

  // Mirror of the queue contents, kept in insertion order
  logic signed [31:0] held_value [DEPTH];
  logic [15:0]        held_priority [DEPTH];
  int                 held_count = 0;

  // Responses still owed by the block, oldest first
  rsp_t awaited_rsp[$];
  int   mismatch_count = 0;

  assign errors = mismatch_count;

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Apply one command to the mirror and return the response it must produce
  function automatic rsp_t apply_command(input req_t r);
    rsp_t res;
    int   best;
    res = '0;
    res.status = ST_OK;
    case (r.cmd)
      CMD_INSERT: begin
        if (held_count == DEPTH) begin
          res.status = ST_FULL;
        end else begin
          held_value[held_count] = r.item_value;
          held_priority[held_count] = r.item_priority;
          held_count++;
        end
      end
      CMD_PEEK, CMD_DELETE: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // earliest entry wins among equal priorities: strict compare only
          best = 0;
          for (int i = 1; i < held_count; i++) begin
            if (held_priority[i] > held_priority[best]) best = i;
          end
          res.out_value = held_value[best];
          res.out_priority = held_priority[best];
          if (r.cmd == CMD_DELETE) begin
            // close the gap, keeping insertion order
            for (int j = best; j < held_count - 1; j++) begin
              held_value[j] = held_value[j + 1];
              held_priority[j] = held_priority[j + 1];
            end
            held_count--;
          end
        end
      end
      default: ;  // unused code leaves the queue alone
    endcase
    return res;
  endfunction

  // Check each response transfer, then predict for each request transfer
  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      held_count = 0;
      awaited_rsp.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsp.size() == 0) begin
          report_mismatch($sformatf("response with none outstanding (value %0d prio %0d)",
                                    rsp.out_value, rsp.out_priority));
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp.out_value !== want.out_value)
            report_mismatch($sformatf("out_value %0d, expected %0d",
                                      rsp.out_value, want.out_value));
          if (rsp.out_priority !== want.out_priority)
            report_mismatch($sformatf("out_priority %0d, expected %0d",
                                      rsp.out_priority, want.out_priority));
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      rsp.status, want.status));
        end
      end
      if (req_valid && req_ready) awaited_rsp.push_back(apply_command(req));
    end
    outstanding <= awaited_rsp.size();
  end

endmodule

// File: sim/bounded_priority_queue_tb.sv
`timescale 1ns / 1ps

module bounded_priority_queue_tb;
  import bpq_pkg::*;

  localparam int   DEPTH        = 8;
  localparam int   RANDOM_ITEMS = 700;
  localparam int   LONG_STALL   = 40;
  localparam int   TAIL_CYCLES  = 10;
  localparam int   CYCLE_LIMIT  = 200000;
  localparam cmd_t CMD_UNUSED   = cmd_t'(2'd3);

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_t        rsp;
  int unsigned outstanding;
  int          errors;
  int          long_stalls_asked = 0;

  bounded_priority_queue #(
    .DEPTH(DEPTH),
    .PRIO_BITS(16)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  bounded_priority_queue_check #(
    .DEPTH(DEPTH)
  ) queue_check (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .outstanding(outstanding),
    .errors(errors)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bound the run length
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // Response side: changing stall patterns, plus long hold-offs on request
  initial begin : rsp_side
    int seg_left;
    int mode;
    int stalls_done;
    seg_left = 0;
    mode = 0;
    stalls_done = 0;
    while (rst) @(posedge clk);
    forever begin
      if (long_stalls_asked != stalls_done) begin
        stalls_done = long_stalls_asked;
        rsp_ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 3);
          seg_left = $urandom_range(5, 40);
        end
        seg_left--;
        case (mode)
          0: rsp_ready <= 1'b1;
          1: rsp_ready <= 1'($urandom_range(0, 1));
          2: rsp_ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic req_t make_req(input cmd_t c, input logic signed [31:0] v,
                                    input logic [15:0] p);
    req_t r;
    r.cmd = c;
    r.item_value = v;
    r.item_priority = p;
    return r;
  endfunction

  // Draw a command; insert_pct steers the fill level up or down
  function automatic req_t random_req(input int insert_pct);
    int               roll;
    cmd_t             c;
    logic signed [31:0] v;
    logic [15:0]      p;
    roll = $urandom_range(0, 99);
    if (roll < 3) c = CMD_UNUSED;
    else if (roll < 20) c = CMD_PEEK;
    else if (roll < 20 + insert_pct * 80 / 100) c = CMD_INSERT;
    else c = CMD_DELETE;
    case ($urandom_range(0, 9))
      0: v = 32'sh8000_0000;
      1: v = 32'sh7FFF_FFFF;
      default: v = $urandom;
    endcase
    case ($urandom_range(0, 7))
      0: p = 16'h0000;
      1: p = 16'hFFFF;
      2, 3, 4: p = 16'($urandom_range(0, 3));
      default: p = 16'($urandom_range(0, 65535));
    endcase
    return make_req(c, v, p);
  endfunction

  // Present one request and hold it until the transfer
  task automatic offer(input req_t r);
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic pause(input int n);
    req_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop sending until every owed response has come back
  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    req_t directed [$];
    int   sent;
    int   burst_left;
    int   phase_left;
    int   insert_pct;
    req_t r;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty queue, extremes, ties, full queue, unused code, drain to empty
    directed = '{
      make_req(CMD_PEEK,   32'sd0,           16'd0),
      make_req(CMD_DELETE, 32'sd0,           16'd0),
      make_req(CMD_UNUSED, 32'sd0,           16'd0),
      make_req(CMD_INSERT, 32'sh8000_0000,   16'h0000),
      make_req(CMD_INSERT, 32'sh7FFF_FFFF,   16'hFFFF),
      make_req(CMD_INSERT, 32'sd5,           16'd100),
      make_req(CMD_INSERT, 32'sd6,           16'hFFFF),
      make_req(CMD_INSERT, 32'sd7,           16'd100),
      make_req(CMD_INSERT, 32'sd0,           16'd0),
      make_req(CMD_INSERT, -32'sd1,          16'd1),
      make_req(CMD_INSERT, 32'sd8,           16'd0),
      make_req(CMD_INSERT, 32'sd9,           16'hFFFF),
      make_req(CMD_PEEK,   32'sd0,           16'd0),
      make_req(CMD_DELETE, 32'sd0,           16'd0),
      make_req(CMD_DELETE, 32'sd0,           16'd0),
      make_req(CMD_PEEK,   32'sd0,           16'd0),
      make_req(CMD_UNUSED, 32'sh5A5A_5A5A,   16'hA5A5),
      make_req(CMD_DELETE, 32'sd0,           16'd0),
      make_req(CMD_DELETE, 32'sd0,           16'd0),
      make_req(CMD_DELETE, 32'sd0,           16'd0),
      make_req(CMD_DELETE, 32'sd0,           16'd0),
      make_req(CMD_DELETE, 32'sd0,           16'd0),
      make_req(CMD_DELETE, 32'sd0,           16'd0),
      make_req(CMD_DELETE, 32'sd0,           16'd0),
      make_req(CMD_INSERT, -32'sh5A5A_5A5B,  16'h8000)
    };
    foreach (directed[i]) offer(directed[i]);
    settle();

    // Hold off the response side and keep requests coming so the input stalls
    long_stalls_asked <= long_stalls_asked + 1;
    for (int i = 0; i < 24; i++) offer(random_req(60));
    settle();

    // Random traffic in bursts, with the fill level swept up and down
    sent = 0;
    burst_left = 0;
    phase_left = 0;
    insert_pct = 50;
    while (sent < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(30, 60);
        case ($urandom_range(0, 2))
          0: insert_pct = 75;
          1: insert_pct = 25;
          default: insert_pct = 50;
        endcase
      end
      phase_left--;
      r = random_req(insert_pct);
      offer(r);
      if (r.cmd != CMD_UNUSED) sent++;
      if (sent == RANDOM_ITEMS / 2 && r.cmd != CMD_UNUSED) begin
        settle();
        long_stalls_asked <= long_stalls_asked + 1;
        for (int i = 0; i < 16; i++) offer(random_req(75));
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
      end else begin
        burst_left--;
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
